// ===== src/msas_pkg.sv =====
package msas_pkg;

  // register file size and the registers actually reachable by a 5-bit index
  localparam int NUM_REGS  = 32;
  localparam int REGS_USED = (NUM_REGS > 32) ? 32 : NUM_REGS;
  localparam logic [4:0] LAST_REG = 5'(REGS_USED - 1);

  localparam logic [31:0] FULL_WORD = 32'hffff_ffff;
  localparam logic [6:0]  WORD_BYTES = 7'd4;
  localparam logic [6:0]  IMM_ZERO_COUNT = 7'd32;

  // instruction kinds, bit 0 is the store flag and bit 1 the string flag
  typedef enum logic [1:0] {
    REQ_LMW  = 2'd0,
    REQ_STMW = 2'd1,
    REQ_LSW  = 2'd2,
    REQ_STSW = 2'd3
  } req_type_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } msas_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last;
  } msas_sts_t;

  // start register reduced into the used register range
  function automatic logic [4:0] reg_wrap(input logic [4:0] r);
    logic [5:0] v;
    v = {1'b0, r};
    for (int i = 0; i < 4; i++) begin
      if (v >= 6'(REGS_USED)) begin
        v = v - 6'(REGS_USED);
      end
    end
    return v[4:0];
  endfunction

  // next register of a string run, wrapping around the register file
  function automatic logic [4:0] reg_next(input logic [4:0] r);
    logic [5:0] n;
    n = {1'b0, r} + 6'd1;
    return (n == 6'(REGS_USED)) ? 5'd0 : n[4:0];
  endfunction

  // keep mask for a partial final load of 1 to 3 bytes
  function automatic logic [31:0] tail_mask(input logic [1:0] rem);
    logic [31:0] m;
    case (rem)
      2'd1:    m = 32'hff00_0000;
      2'd2:    m = 32'hffff_0000;
      2'd3:    m = 32'hffff_ff00;
      default: m = FULL_WORD;
    endcase
    return m;
  endfunction

endpackage

// ===== src/msas_in_if.sv =====
interface msas_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  start_reg;
  logic [31:0] base_addr;
  logic [6:0]  byte_count;
  logic        count_is_immediate;

  modport source (
    output valid, req_type, start_reg, base_addr, byte_count, count_is_immediate,
    input  ready
  );

  modport sink (
    input  valid, req_type, start_reg, base_addr, byte_count, count_is_immediate,
    output ready
  );
endinterface

// ===== src/msas_out_if.sv =====
interface msas_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] access_addr;
  logic [4:0]  reg_index;
  logic        is_store;
  logic        is_byte;
  logic [1:0]  byte_lane;
  logic [31:0] keep_mask;
  logic        last;

  modport source (
    output valid, access_addr, reg_index, is_store, is_byte, byte_lane, keep_mask, last,
    input  ready
  );

  modport sink (
    input  valid, access_addr, reg_index, is_store, is_byte, byte_lane, keep_mask, last,
    output ready
  );
endinterface

// ===== src/msas_datapath.sv =====
module msas_datapath (
  input  logic               clk,
  input  msas_pkg::msas_cmd_t cmd,
  output msas_pkg::msas_sts_t sts,
  input  logic [1:0]         req_type,
  input  logic [4:0]         start_reg,
  input  logic [31:0]        base_addr,
  input  logic [6:0]         byte_count,
  input  logic               count_is_immediate,
  output logic [31:0]        access_addr,
  output logic [4:0]         reg_index,
  output logic               is_store,
  output logic               is_byte,
  output logic [1:0]         byte_lane,
  output logic [31:0]        keep_mask,
  output logic               last
);
  import msas_pkg::*;

  // run state
  logic [1:0]  type_r;
  logic [31:0] addr_r, addr_nxt;
  logic [4:0]  reg_r, reg_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [1:0]  lane_r, lane_nxt;

  // output register
  logic [31:0] access_addr_r;
  logic [4:0]  reg_index_r;
  logic        is_store_r;
  logic        is_byte_r;
  logic [1:0]  byte_lane_r;
  logic [31:0] keep_mask_r;
  logic        last_r;

  // current access
  logic        cur_byte;
  logic [31:0] cur_mask;
  logic        cur_last;

  // effective byte count of the incoming transaction
  logic [6:0] in_count;
  logic       in_string;

  assign in_string = req_type[1];

  always_comb begin
    in_count = byte_count;
    if (count_is_immediate) begin
      in_count = (byte_count[4:0] == 5'd0) ? IMM_ZERO_COUNT : {2'b00, byte_count[4:0]};
    end
  end

  // empty runs: multiple form above the last register, or zero count from xer
  always_comb begin
    if (in_string) begin
      sts.empty = !count_is_immediate && (byte_count == 7'd0);
    end else begin
      sts.empty = {1'b0, start_reg} > 6'(REGS_USED - 1);
    end
  end

  // decode the access at the head of the run and its successor
  always_comb begin
    cur_byte = 1'b0;
    cur_mask = type_r[0] ? 32'd0 : FULL_WORD;
    cur_last = 1'b0;
    addr_nxt = addr_r + 32'd4;
    reg_nxt  = reg_r;
    rem_nxt  = rem_r;
    lane_nxt = 2'd0;
    if (!type_r[1]) begin
      cur_last = (reg_r == LAST_REG);
      reg_nxt  = reg_r + 5'd1;
    end else if (rem_r >= WORD_BYTES) begin
      cur_last = (rem_r == WORD_BYTES);
      rem_nxt  = rem_r - WORD_BYTES;
      reg_nxt  = reg_next(reg_r);
    end else if (!type_r[0]) begin
      cur_mask = tail_mask(rem_r[1:0]);
      cur_last = 1'b1;
    end else begin
      cur_byte = 1'b1;
      cur_last = ({5'd0, lane_r} + 7'd1 == rem_r);
      addr_nxt = addr_r + 32'd1;
      lane_nxt = lane_r + 2'd1;
    end
  end

  assign sts.last = cur_last;

  // run registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= req_type;
      addr_r <= base_addr;
      reg_r  <= in_string ? reg_wrap(start_reg) : start_reg;
      rem_r  <= in_count;
      lane_r <= 2'd0;
    end else if (cmd.step) begin
      addr_r <= addr_nxt;
      reg_r  <= reg_nxt;
      rem_r  <= rem_nxt;
      lane_r <= lane_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      access_addr_r <= addr_r;
      reg_index_r   <= reg_r;
      is_store_r    <= type_r[0];
      is_byte_r     <= cur_byte;
      byte_lane_r   <= cur_byte ? lane_r : 2'd0;
      keep_mask_r   <= cur_mask;
      last_r        <= cur_last;
    end
  end

  assign access_addr = access_addr_r;
  assign reg_index   = reg_index_r;
  assign is_store    = is_store_r;
  assign is_byte     = is_byte_r;
  assign byte_lane   = byte_lane_r;
  assign keep_mask   = keep_mask_r;
  assign last        = last_r;

  // a byte store never runs past the tail bytes
  a_lane_in_tail: assert property (@(posedge clk)
    (cmd.step && cur_byte) |-> ({5'd0, lane_r} < rem_r))
    else $error("byte lane beyond tail count");

endmodule

// ===== src/msas_ctrl.sv =====
module msas_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output msas_pkg::msas_cmd_t cmd,
  input  msas_pkg::msas_sts_t sts
);
  import msas_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register can take a new access
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.step = (state_r == ST_RUN) && slot_free;

  // next state and result valid
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load && !sts.empty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd.step && sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.step)
    else $error("result overwritten while stalled");

  // an empty instruction leaves the sequencer idle
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.empty) |=> (state_r == ST_IDLE))
    else $error("empty instruction started a run");

  // a non-empty instruction starts a run
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !sts.empty) |=> (state_r == ST_RUN))
    else $error("instruction dropped");

  // a run only ends on its last access
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) ##1 (state_r == ST_IDLE)) |-> $past(cmd.step && sts.last))
    else $error("run ended before last access");

endmodule

// ===== src/multiple_and_string_access_sequencer.sv =====
// Load/store multiple and string access sequencer.
// in_ch carries one instruction per transaction: kind, start register,
// effective address and byte count. out_ch carries one memory access per
// transaction, the final one of an instruction flagged by last.
// Both channels use valid/ready; a transaction moves when both are high.
// An accepted instruction is first loaded into the run registers, and
// each step then moves one access into the output register. Accesses
// follow one per cycle while out_ch.ready stays high. An instruction
// has 1 to 34 accesses, or none (zero count from XER, or a multiple
// form starting above the last register); then no run is started.
// The rate is set by the single access generator, which steps, unless
// stalled, once per cycle through the run's address, register and tail
// byte counters. in_ch.ready is high while no run is in progress, even
// if the last access still waits in the output register.
// When out_ch.ready is low the output register holds its access and the
// generator stalls. Synchronous reset drops any run in progress and
// clears out_ch.valid; no clearing pass is needed.
module multiple_and_string_access_sequencer (
  input logic      clk,
  input logic      rst_n,
  msas_in_if.sink  in_ch,
  msas_out_if.source out_ch
);
  import msas_pkg::*;

  msas_cmd_t cmd;
  msas_sts_t sts;

  // sequencing control
  msas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // address, register and mask generation
  msas_datapath u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .sts                (sts),
    .req_type           (in_ch.req_type),
    .start_reg          (in_ch.start_reg),
    .base_addr          (in_ch.base_addr),
    .byte_count         (in_ch.byte_count),
    .count_is_immediate (in_ch.count_is_immediate),
    .access_addr        (out_ch.access_addr),
    .reg_index          (out_ch.reg_index),
    .is_store           (out_ch.is_store),
    .is_byte            (out_ch.is_byte),
    .byte_lane          (out_ch.byte_lane),
    .keep_mask          (out_ch.keep_mask),
    .last               (out_ch.last)
  );

endmodule
